### src/midi_event_transform_note_tracker_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the MIDI event transform and note tracker.
// Shared property forms used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef MIDI_EVENT_TRANSFORM_NOTE_TRACKER_TOP_DEFINES_SVH
`define MIDI_EVENT_TRANSFORM_NOTE_TRACKER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MET_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define MET_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/met_pkg.sv
// ----------------------------------------------------------------------------
// MIDI event transform package
// Shared constants, codes and the held-note chain control structure.
// ----------------------------------------------------------------------------
`default_nettype none
package met_pkg;

    localparam int NOTE_SLOTS = 32;
    localparam int TIME_BITS  = 32;
    localparam int CNT_W      = $clog2(NOTE_SLOTS + 1);
    localparam int KEY_W      = 11;
    localparam int UNIT_W     = 20;

    localparam logic [1:0] ACT_EVENT   = 2'd0;
    localparam logic [1:0] ACT_LOAD    = 2'd1;
    localparam logic [1:0] ACT_ALL_OFF = 2'd2;

    localparam logic [1:0] KIND_OFF    = 2'd0;
    localparam logic [1:0] KIND_ON     = 2'd1;
    localparam logic [1:0] KIND_OTHER  = 2'd2;

    localparam logic [1:0] CFG_CHAN_SEL  = 2'd0;
    localparam logic [1:0] CFG_TRANSPOSE = 2'd1;
    localparam logic [1:0] CFG_QUANT_ON  = 2'd2;
    localparam logic [1:0] CFG_QUANT_U   = 2'd3;

    localparam logic [6:0] ALL_OFF_VEL = 7'd64;

    typedef struct packed {
        logic             shift;
        logic             keep;
        logic [CNT_W-1:0] limit;
        logic [KEY_W-1:0] head;
        logic             append;
        logic [CNT_W-1:0] app_pos;
        logic [KEY_W-1:0] app_key;
    } t_chain_ctl;

endpackage
`default_nettype wire

### src/met_cell.sv
// ----------------------------------------------------------------------------
// Held-note cell
// Holds one held-note key; loads appends and shifts in neighbor or head keys.
// ----------------------------------------------------------------------------
`default_nettype none
module met_cell (
    input  wire logic                        i_clk,
    input  wire met_pkg::t_chain_ctl         i_ctl,
    input  wire logic [met_pkg::CNT_W-1:0]   i_index,
    input  wire logic [met_pkg::KEY_W-1:0]   i_next_key,
    output logic      [met_pkg::KEY_W-1:0]   o_key
);

    logic [met_pkg::KEY_W-1:0] r_key;
    logic [met_pkg::CNT_W:0]   w_pos;

    assign w_pos = {1'b0, i_index} + {{met_pkg::CNT_W{1'b0}}, 1'b1};
    assign o_key = r_key;

    always_ff @(posedge i_clk) begin
        if (i_ctl.append && (i_ctl.app_pos == i_index)) begin
            r_key <= i_ctl.app_key;
        end else if (i_ctl.shift) begin
            if (w_pos < {1'b0, i_ctl.limit}) begin
                r_key <= i_next_key;
            end else if ((w_pos == {1'b0, i_ctl.limit}) && i_ctl.keep) begin
                r_key <= i_ctl.head;
            end
        end
    end

endmodule
`default_nettype wire

### src/met_chain.sv
// ----------------------------------------------------------------------------
// Held-note chain
// A row of cells that appends, compacts and rotates the held notes.
// ----------------------------------------------------------------------------
`default_nettype none
module met_chain (
    input  wire logic                        i_clk,
    input  wire met_pkg::t_chain_ctl         i_ctl,
    output logic      [met_pkg::KEY_W-1:0]   o_head
);

    logic [met_pkg::KEY_W-1:0] w_key [met_pkg::NOTE_SLOTS];

    genvar g;
    generate
        for (g = 0; g < met_pkg::NOTE_SLOTS; g++) begin : g_cell
            logic [met_pkg::KEY_W-1:0] w_next;
            if (g == met_pkg::NOTE_SLOTS - 1) begin : g_last
                assign w_next = w_key[g];
            end else begin : g_mid
                assign w_next = w_key[g+1];
            end
            met_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (i_ctl),
                .i_index    (met_pkg::CNT_W'(g)),
                .i_next_key (w_next),
                .o_key      (w_key[g])
            );
        end
    endgenerate

    assign o_head = w_key[0];

endmodule
`default_nettype wire

### src/met_qdiv.sv
// ----------------------------------------------------------------------------
// Quantize divider
// Restoring divider of the timestamp by the grid unit, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module met_qdiv (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [met_pkg::TIME_BITS-1:0]  i_dividend,
    input  wire logic [met_pkg::UNIT_W-1:0]     i_divisor,
    output logic                                o_done,
    output logic      [met_pkg::TIME_BITS-1:0]  o_quot,
    output logic      [met_pkg::UNIT_W-1:0]     o_rem
);

    localparam int CW = $clog2(met_pkg::TIME_BITS + 1);

    logic                          r_run;
    logic [CW-1:0]                 r_cnt;
    logic [met_pkg::TIME_BITS-1:0] r_quot;
    logic [met_pkg::UNIT_W:0]      r_rem;
    logic                          r_done;
    logic [met_pkg::UNIT_W:0]      w_sh;
    logic                          w_ge;

    assign w_sh = {r_rem[met_pkg::UNIT_W-1:0], r_quot[met_pkg::TIME_BITS-1]};
    assign w_ge = (w_sh >= {1'b0, i_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CW'(met_pkg::TIME_BITS);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
        end else if (r_run) begin
            r_quot <= {r_quot[met_pkg::TIME_BITS-2:0], w_ge};
            r_rem  <= w_ge ? (w_sh - {1'b0, i_divisor}) : w_sh;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem[met_pkg::UNIT_W-1:0];

endmodule
`default_nettype wire

### src/midi_event_transform_note_tracker_top.sv
// ----------------------------------------------------------------------------
// MIDI event transform and note tracker
// Filters, transposes and velocity-maps MIDI events and tracks held notes.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Each result beat shows
// on the o_ ports for one cycle with o_strobe high; o_last_of_run marks the
// final beat of an item. The receiver cannot stall, so no beat is held back.
// A table load or an unused action gives no beat. A dropped event gives its
// beat from the evaluate state. Any other event goes on, through the remove
// state when a note off or a zero-velocity note on scans the held-note chain,
// to the time state and, when quantization is on, through the divider and the
// multiply and saturate states. All notes off gives one beat per held note in
// consecutive cycles while the chain rotates past its head cell. Busy falls
// in the cycle of the last beat, so the next item can be taken then.
// Configuration is written through i_cfg_we, i_cfg_index and i_cfg_data only
// while the block is idle; the user must see to this, as the block does not
// enforce it. Reset empties the held notes, restores the identity velocity
// table through per-entry valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none
module midi_event_transform_note_tracker_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [19:0] i_cfg_data,
    input  wire logic [1:0]  i_action,
    input  wire logic [1:0]  i_event_kind,
    input  wire logic [3:0]  i_chan,
    input  wire logic [6:0]  i_first_data,
    input  wire logic [6:0]  i_second_data,
    input  wire logic [31:0] i_time_stamp,
    input  wire logic [6:0]  i_curve_index,
    input  wire logic [6:0]  i_curve_value,
    output logic             o_strobe,
    output logic [1:0]       o_out_kind,
    output logic [3:0]       o_out_chan,
    output logic [6:0]       o_out_first,
    output logic [6:0]       o_out_second,
    output logic [31:0]      o_out_time,
    output logic             o_dropped,
    output logic             o_notes_full,
    output logic             o_last_of_run
);

    localparam int CW = met_pkg::CNT_W;
    localparam int TB = met_pkg::TIME_BITS;
    localparam int UW = met_pkg::UNIT_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_REM  = 3'd2;
    localparam logic [2:0] S_TIME = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_MUL  = 3'd5;
    localparam logic [2:0] S_SAT  = 3'd6;
    localparam logic [2:0] S_OFF  = 3'd7;

    logic [2:0]    r_state;
    logic [4:0]    r_chan_sel;
    logic [7:0]    r_transpose;
    logic          r_quant_on;
    logic [UW-1:0] r_quant_u;

    logic [6:0]    r_vel_mem [128];
    logic [127:0]  r_vel_vld;
    logic [6:0]    r_vel_rd;
    logic          r_vel_rdv;

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_rem;
    logic [CW-1:0] r_kept;

    logic [1:0]    r_kind;
    logic [3:0]    r_chan;
    logic [6:0]    r_d1;
    logic [6:0]    r_d2;
    logic [TB-1:0] r_time;
    logic          r_drop;
    logic          r_full;
    logic [TB:0]   r_k;
    logic [TB+UW:0] r_prod;

    logic          r_strobe;
    logic [1:0]    r_o_kind;
    logic [3:0]    r_o_chan;
    logic [6:0]    r_o_first;
    logic [6:0]    r_o_second;
    logic [TB-1:0] r_o_time;
    logic          r_o_drop;
    logic          r_o_full;
    logic          r_o_last;

    logic                      w_accept;
    logic [1:0]                w_kind;
    logic                      w_is_note;
    logic [8:0]                w_nt;
    logic                      w_drop;
    logic [6:0]                w_vel_map;
    logic [UW-1:0]             w_unit;
    logic                      w_div_start;
    logic                      w_div_done;
    logic [TB-1:0]             w_quot;
    logic [UW-1:0]             w_rem;
    logic                      w_inc;
    logic [met_pkg::KEY_W-1:0] w_head;
    logic [met_pkg::KEY_W-1:0] w_key;
    met_pkg::t_chain_ctl       w_ctl;

    assign w_accept  = start && !busy;
    assign busy      = (r_state != S_IDLE);
    assign w_kind    = (i_event_kind == met_pkg::KIND_OFF) ? met_pkg::KIND_OFF :
                       (i_event_kind == met_pkg::KIND_ON)  ? met_pkg::KIND_ON  :
                                                             met_pkg::KIND_OTHER;
    assign w_is_note = (w_kind != met_pkg::KIND_OTHER);
    assign w_nt      = {2'b00, i_first_data} + {r_transpose[7], r_transpose};
    assign w_drop    = (!r_chan_sel[4] && (i_chan != r_chan_sel[3:0])) ||
                       (w_is_note && (w_nt[8] || w_nt[7]));
    assign w_vel_map = r_vel_rdv ? r_vel_rd : ((r_d2 == 7'd0) ? 7'd1 : r_d2);
    assign w_unit    = (r_quant_u == '0) ? UW'(1) : r_quant_u;
    assign w_key     = {r_chan, r_d1};
    assign w_div_start = (r_state == S_TIME) && r_quant_on;
    assign w_inc     = ({1'b0, w_rem} >= ({1'b0, w_unit} - {1'b0, w_rem}));

    always_comb begin
        w_ctl         = '0;
        w_ctl.head    = w_head;
        w_ctl.limit   = r_rem + r_kept;
        w_ctl.app_pos = r_count;
        w_ctl.app_key = w_key;
        if (r_state == S_EVAL) begin
            w_ctl.append = !r_drop && (r_kind == met_pkg::KIND_ON) && (r_d2 != 7'd0) &&
                           (r_count < CW'(met_pkg::NOTE_SLOTS));
        end
        if ((r_state == S_REM) && (r_rem != '0)) begin
            w_ctl.shift = 1'b1;
            w_ctl.keep  = (w_head != w_key);
        end
        if (r_state == S_OFF) begin
            w_ctl.shift = 1'b1;
            w_ctl.keep  = 1'b1;
        end
    end

    met_chain u_chain (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .o_head (w_head)
    );

    met_qdiv u_qdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_time),
        .i_divisor  (w_unit),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_sel  <= 5'h1F;
            r_transpose <= '0;
            r_quant_on  <= 1'b0;
            r_quant_u   <= UW'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                met_pkg::CFG_CHAN_SEL:  r_chan_sel  <= i_cfg_data[4:0];
                met_pkg::CFG_TRANSPOSE: r_transpose <= i_cfg_data[7:0];
                met_pkg::CFG_QUANT_ON:  r_quant_on  <= i_cfg_data[0];
                met_pkg::CFG_QUANT_U:   r_quant_u   <= i_cfg_data[UW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (i_action == met_pkg::ACT_LOAD)) begin
            r_vel_mem[i_curve_index] <= (i_curve_value == 7'd0) ? 7'd1 : i_curve_value;
        end
        r_vel_rd <= r_vel_mem[i_second_data];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel_vld <= '0;
            r_vel_rdv <= 1'b0;
        end else begin
            r_vel_rdv <= r_vel_vld[i_second_data];
            if (w_accept && (i_action == met_pkg::ACT_LOAD)) begin
                r_vel_vld[i_curve_index] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= w_kind;
            r_chan <= i_chan;
            r_d1   <= (w_is_note && !w_drop) ? w_nt[6:0] : i_first_data;
            r_d2   <= i_second_data;
            r_time <= i_time_stamp;
            r_drop <= w_drop;
            r_full <= 1'b0;
        end else if (r_state == S_EVAL) begin
            if (!r_drop && (r_kind == met_pkg::KIND_ON) && (r_d2 != 7'd0)) begin
                r_d2   <= w_vel_map;
                r_full <= (r_count >= CW'(met_pkg::NOTE_SLOTS));
            end
        end
        if (w_div_done) begin
            r_k <= {1'b0, w_quot} + {{TB{1'b0}}, w_inc};
        end
        if (r_state == S_MUL) begin
            r_prod <= r_k * w_unit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_rem    <= '0;
            r_kept   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_action == met_pkg::ACT_EVENT) begin
                            r_state <= S_EVAL;
                        end else if ((i_action == met_pkg::ACT_ALL_OFF) &&
                                     (r_count != '0)) begin
                            r_rem   <= r_count;
                            r_kept  <= '0;
                            r_state <= S_OFF;
                        end
                    end
                end
                S_EVAL: begin
                    if (r_drop) begin
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end else if ((r_kind == met_pkg::KIND_ON) && (r_d2 != 7'd0)) begin
                        if (r_count < CW'(met_pkg::NOTE_SLOTS)) begin
                            r_count <= r_count + 1'b1;
                        end
                        r_state <= S_TIME;
                    end else if (r_kind != met_pkg::KIND_OTHER) begin
                        r_rem   <= r_count;
                        r_kept  <= '0;
                        r_state <= S_REM;
                    end else begin
                        r_state <= S_TIME;
                    end
                end
                S_REM: begin
                    if (r_rem == '0) begin
                        r_count <= r_kept;
                        r_state <= S_TIME;
                    end else begin
                        r_rem <= r_rem - 1'b1;
                        if (w_ctl.keep) begin
                            r_kept <= r_kept + 1'b1;
                        end
                    end
                end
                S_TIME: begin
                    if (r_quant_on) begin
                        r_state <= S_DIV;
                    end else begin
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_OFF: begin
                    r_strobe <= 1'b1;
                    r_rem    <= r_rem - 1'b1;
                    if (r_rem == CW'(1)) begin
                        r_count <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OFF) begin
            r_o_kind   <= met_pkg::KIND_OFF;
            r_o_chan   <= w_head[10:7];
            r_o_first  <= w_head[6:0];
            r_o_second <= met_pkg::ALL_OFF_VEL;
            r_o_time   <= '0;
            r_o_drop   <= 1'b0;
            r_o_full   <= 1'b0;
            r_o_last   <= (r_rem == CW'(1));
        end else begin
            r_o_kind   <= r_kind;
            r_o_chan   <= r_chan;
            r_o_first  <= r_d1;
            r_o_second <= r_d2;
            r_o_drop   <= r_drop;
            r_o_full   <= r_full;
            r_o_last   <= 1'b1;
            if (r_state == S_SAT) begin
                r_o_time <= (r_prod[TB+UW:TB] != '0) ? {TB{1'b1}} : r_prod[TB-1:0];
            end else begin
                r_o_time <= r_time;
            end
        end
    end

    assign o_strobe      = r_strobe;
    assign o_out_kind    = r_o_kind;
    assign o_out_chan    = r_o_chan;
    assign o_out_first   = r_o_first;
    assign o_out_second  = r_o_second;
    assign o_out_time    = r_o_time;
    assign o_dropped     = r_o_drop;
    assign o_notes_full  = r_o_full;
    assign o_last_of_run = r_o_last;

endmodule
`default_nettype wire

### src/met_checker.sv
// ----------------------------------------------------------------------------
// Port checker
// Checks beat sequencing and the full flag at the MIDI event transform ports.
// ----------------------------------------------------------------------------
`default_nettype none
`include "midi_event_transform_note_tracker_top_defines.svh"
module met_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       busy,
    input wire logic       o_strobe,
    input wire logic [1:0] o_out_kind,
    input wire logic       o_dropped,
    input wire logic       o_notes_full,
    input wire logic       o_last_of_run
);

    `MET_ASSERT_NEXT(a_run_continues, i_clk, i_rst_n, o_strobe && !o_last_of_run, o_strobe, "gap in a result run")
    `MET_ASSERT_NOW(a_run_busy, i_clk, i_rst_n, o_strobe && !o_last_of_run, busy, "idle during a result run")
    `MET_ASSERT_NOW(a_drop_single, i_clk, i_rst_n, o_strobe && o_dropped, o_last_of_run, "dropped beat not last")
    `MET_ASSERT_NOW(a_full_is_on, i_clk, i_rst_n, o_strobe && o_notes_full, o_out_kind == met_pkg::KIND_ON && !o_dropped, "full flag off a note on")

endmodule

bind midi_event_transform_note_tracker_top met_checker u_met_checker (.*);
`default_nettype wire

### test/tb_midi_event_transform_note_tracker_top.sv
// ----------------------------------------------------------------------------
// Testbench for the MIDI event transform and note tracker
// Drives directed and random items through the command port, predicts every
// result beat with an independent model of filtering, transposition, velocity
// mapping, held-note tracking and quantization, and compares beat by beat.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_midi_event_transform_note_tracker_top;
    import met_pkg::*;

    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  kind;
        logic [3:0]  chan;
        logic [6:0]  first;
        logic [6:0]  second;
        logic [31:0] tstamp;
        logic [6:0]  cidx;
        logic [6:0]  cval;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  chan;
        logic [6:0]  first;
        logic [6:0]  second;
        logic [31:0] tstamp;
        logic        dropped;
        logic        full;
        logic        last;
    } t_beat;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [19:0] i_cfg_data = '0;
    logic [1:0]  i_action = '0;
    logic [1:0]  i_event_kind = '0;
    logic [3:0]  i_chan = '0;
    logic [6:0]  i_first_data = '0;
    logic [6:0]  i_second_data = '0;
    logic [31:0] i_time_stamp = '0;
    logic [6:0]  i_curve_index = '0;
    logic [6:0]  i_curve_value = '0;
    logic        o_strobe;
    logic [1:0]  o_out_kind;
    logic [3:0]  o_out_chan;
    logic [6:0]  o_out_first;
    logic [6:0]  o_out_second;
    logic [31:0] o_out_time;
    logic        o_dropped;
    logic        o_notes_full;
    logic        o_last_of_run;

    midi_event_transform_note_tracker_top i_dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state.
    logic signed [4:0] chan_keep;
    logic signed [7:0] semitones;
    logic              grid_on;
    logic [19:0]       grid_unit;
    logic [6:0]        vel_map [128];
    logic [10:0]       held_keys [NOTE_SLOTS];
    int                held_cnt;

    t_beat expected_beats [$];
    int    errors = 0;
    int    idle_pct = 0;

    function automatic logic [31:0] round_to_grid(input logic [31:0] t);
        logic [63:0] u, k, r;
        u = (grid_unit == 0) ? 64'd1 : 64'(grid_unit);
        k = 64'(t) / u;
        r = 64'(t) % u;
        if (r >= u - r) k++;
        if (k > 64'hFFFF_FFFF / u) return 32'hFFFF_FFFF;
        return 32'(k * u);
    endfunction

    task automatic add_expected(input t_beat b);
        expected_beats = {expected_beats, b};
    endtask

    task automatic predict_item(input t_item it);
        t_beat b;
        logic [1:0] k;
        int nt, w;
        logic [10:0] key;
        if (it.action == ACT_LOAD) begin
            vel_map[it.cidx] = (it.cval == 0) ? 7'd1 : it.cval;
        end else if (it.action == ACT_ALL_OFF) begin
            for (int i = 0; i < held_cnt; i++) begin
                b = '{KIND_OFF, held_keys[i][10:7], held_keys[i][6:0], ALL_OFF_VEL,
                      32'd0, 1'b0, 1'b0, (i == held_cnt - 1)};
                add_expected(b);
            end
            held_cnt = 0;
        end else if (it.action == ACT_EVENT) begin
            k = (it.kind == KIND_SPARE) ? KIND_OTHER : it.kind;
            b = '{k, it.chan, it.first, it.second, it.tstamp, 1'b1, 1'b0, 1'b1};
            if (chan_keep >= 0 && $signed({1'b0, it.chan}) != chan_keep) begin
                add_expected(b);
                return;
            end
            if (k == KIND_OFF || k == KIND_ON) begin
                nt = int'(it.first) + int'(semitones);
                if (nt < 0 || nt > 127) begin
                    add_expected(b);
                    return;
                end
                b.first = 7'(nt);
                key = {it.chan, b.first};
                if (k == KIND_ON && it.second != 0) begin
                    b.second = (vel_map[it.second] == 0) ? 7'd1 : vel_map[it.second];
                    if (held_cnt < NOTE_SLOTS) begin
                        held_keys[held_cnt] = key;
                        held_cnt++;
                    end else begin
                        b.full = 1'b1;
                    end
                end else begin
                    w = 0;
                    for (int i = 0; i < held_cnt; i++)
                        if (held_keys[i] != key) begin
                            held_keys[w] = held_keys[i];
                            w++;
                        end
                    held_cnt = w;
                end
            end
            if (grid_on) b.tstamp = round_to_grid(it.tstamp);
            b.dropped = 1'b0;
            add_expected(b);
        end
    endtask

    // Called at a rising edge; leaves start high unless an idle gap is drawn.
    task automatic send_item(input t_item it);
        i_action      <= it.action;
        i_event_kind  <= it.kind;
        i_chan        <= it.chan;
        i_first_data  <= it.first;
        i_second_data <= it.second;
        i_time_stamp  <= it.tstamp;
        i_curve_index <= it.cidx;
        i_curve_value <= it.cval;
        start         <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_item(it);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            while ($urandom_range(99) < idle_pct) @(posedge i_clk);
            @(posedge i_clk);
        end
    endtask

    task automatic drain;
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // Holds the sender off and waits until no item is in flight before writing.
    task automatic write_reg(input logic [1:0] idx, input logic [19:0] data);
        start <= 1'b0;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_CHAN_SEL:  chan_keep = data[4:0];
            CFG_TRANSPOSE: semitones = data[7:0];
            CFG_QUANT_ON:  grid_on = data[0];
            CFG_QUANT_U:   grid_unit = data;
            default: ;
        endcase
    endtask

    function automatic t_item make_event(input logic [1:0] kind, input logic [3:0] ch,
                                         input logic [6:0] note, input logic [6:0] vel,
                                         input logic [31:0] t);
        t_item it;
        it = '{ACT_EVENT, kind, ch, note, vel, t, 7'($urandom), 7'($urandom)};
        return it;
    endfunction

    function automatic t_item make_plain(input logic [1:0] action);
        t_item it;
        it = t_item'({4'($urandom), $urandom, $urandom});
        it.action = action;
        return it;
    endfunction

    function automatic t_item random_item;
        t_item it;
        int sel;
        sel = $urandom_range(99);
        it = make_plain(ACT_EVENT);
        if (sel < 70) begin
            it.kind  = ($urandom_range(2) == 0) ? KIND_OFF : KIND_ON;
            it.chan  = 4'($urandom_range(2));
            it.first = 7'(58 + $urandom_range(5));
            if ($urandom_range(7) == 0) it.second = 7'd0;
        end else if (sel < 80) begin
            it.action = ACT_LOAD;
        end else if (sel < 86) begin
            it.action = ACT_ALL_OFF;
        end else if (sel < 89) begin
            it.action = ACT_UNUSED;
        end
        return it;
    endfunction

    task automatic test_directed_basics;
        idle_pct = 0;
        send_item(make_event(KIND_ON, 4'd0, 7'd0, 7'd1, 32'd0));
        send_item(make_event(KIND_ON, 4'd15, 7'd127, 7'd127, 32'hFFFF_FFFF));
        send_item(make_event(KIND_ON, 4'd5, 7'd60, 7'd0, 32'd100));
        send_item(make_event(KIND_OFF, 4'd0, 7'd0, 7'd99, 32'd7));
        send_item(make_event(KIND_OTHER, 4'd9, 7'd55, 7'd66, 32'h8000_0000));
        send_item(make_event(KIND_SPARE, 4'd3, 7'd127, 7'd0, 32'h1234_5678));
        send_item(make_plain(ACT_UNUSED));
        send_item('{ACT_LOAD, 2'd0, 4'd0, 7'd0, 7'd0, 32'd0, 7'd100, 7'd0});
        send_item('{ACT_LOAD, 2'd3, 4'd15, 7'd127, 7'd127, 32'hFFFF_FFFF, 7'd127, 7'd127});
        send_item('{ACT_LOAD, 2'd0, 4'd0, 7'd0, 7'd0, 32'd0, 7'd0, 7'd42});
        send_item(make_event(KIND_ON, 4'd2, 7'd64, 7'd100, 32'd9));
        send_item(make_event(KIND_ON, 4'd2, 7'd64, 7'd127, 32'd9));
        send_item(make_event(KIND_ON, 4'd2, 7'd65, 7'd3, 32'd9));
        send_item(make_plain(ACT_ALL_OFF));
        send_item(make_plain(ACT_ALL_OFF));
        send_item(make_event(KIND_ON, 4'd7, 7'd30, 7'd20, 32'd1));
        send_item(make_event(KIND_ON, 4'd7, 7'd30, 7'd20, 32'd2));
        send_item(make_event(KIND_ON, 4'd6, 7'd30, 7'd20, 32'd3));
        send_item(make_event(KIND_ON, 4'd7, 7'd30, 7'd0, 32'd4));
        send_item(make_plain(ACT_ALL_OFF));
        drain();
    endtask

    task automatic test_filter_and_transpose;
        idle_pct = 0;
        write_reg(CFG_CHAN_SEL, 20'd15);
        write_reg(CFG_TRANSPOSE, 20'h0007F);
        send_item(make_event(KIND_ON, 4'd14, 7'd0, 7'd50, 32'd5));
        send_item(make_event(KIND_ON, 4'd15, 7'd0, 7'd50, 32'd5));
        send_item(make_event(KIND_ON, 4'd15, 7'd1, 7'd50, 32'd5));
        send_item(make_event(KIND_OTHER, 4'd15, 7'd1, 7'd50, 32'd5));
        write_reg(CFG_CHAN_SEL, 20'd0);
        write_reg(CFG_TRANSPOSE, 20'h00081);
        send_item(make_event(KIND_OFF, 4'd0, 7'd127, 7'd10, 32'd6));
        send_item(make_event(KIND_OFF, 4'd0, 7'd126, 7'd10, 32'd6));
        send_item(make_event(KIND_ON, 4'd1, 7'd127, 7'd10, 32'd6));
        write_reg(CFG_CHAN_SEL, 20'h00010);
        send_item(make_event(KIND_ON, 4'd11, 7'd127, 7'd10, 32'd6));
        send_item(make_plain(ACT_ALL_OFF));
        drain();
        write_reg(CFG_CHAN_SEL, 20'h0001F);
        write_reg(CFG_TRANSPOSE, 20'd0);
    endtask

    task automatic test_quantize;
        idle_pct = 0;
        write_reg(CFG_QUANT_ON, 20'd1);
        write_reg(CFG_QUANT_U, 20'd4);
        send_item(make_event(KIND_OTHER, 4'd1, 7'd1, 7'd1, 32'd5));
        send_item(make_event(KIND_OTHER, 4'd1, 7'd1, 7'd1, 32'd6));
        send_item(make_event(KIND_OTHER, 4'd1, 7'd1, 7'd1, 32'hFFFF_FFFE));
        drain();
        write_reg(CFG_QUANT_U, 20'hFFFFF);
        send_item(make_event(KIND_OTHER, 4'd1, 7'd1, 7'd1, 32'hFFFF_FFFF));
        send_item(make_event(KIND_OTHER, 4'd1, 7'd1, 7'd1, 32'h0007_FFFF));
        send_item(make_event(KIND_ON, 4'd1, 7'd1, 7'd1, 32'h0008_0000));
        drain();
        write_reg(CFG_QUANT_U, 20'd0);
        send_item(make_event(KIND_OFF, 4'd1, 7'd1, 7'd1, 32'hFFFF_FFFF));
        drain();
        write_reg(CFG_QUANT_U, 20'd3);
        for (int i = 0; i < 6; i++)
            send_item(make_event(KIND_OTHER, 4'd2, 7'd3, 7'd3, $urandom));
        drain();
        write_reg(CFG_QUANT_ON, 20'd0);
        write_reg(CFG_QUANT_U, 20'd1);
    endtask

    task automatic test_full_table;
        idle_pct = 10;
        for (int i = 0; i < NOTE_SLOTS + 3; i++)
            send_item(make_event(KIND_ON, 4'(i), 7'(i), 7'd90, $urandom));
        send_item(make_event(KIND_OFF, 4'd3, 7'd3, 7'd0, 32'd1));
        send_item(make_plain(ACT_ALL_OFF));
        drain();
    endtask

    task automatic test_random(input int count, input int pct);
        idle_pct = pct;
        for (int i = 0; i < count; i++)
            send_item(random_item());
        drain();
    endtask

    task automatic test_random_settings;
        write_reg(CFG_TRANSPOSE, 20'($urandom_range(6)) - 20'd3);
        write_reg(CFG_QUANT_ON, 20'd1);
        write_reg(CFG_QUANT_U, 20'($urandom_range(1000, 1)));
        test_random(40, 81);
        write_reg(CFG_CHAN_SEL, 20'd1);
        write_reg(CFG_QUANT_ON, 20'd0);
        test_random(40, 10);
        write_reg(CFG_CHAN_SEL, 20'h0001F);
        write_reg(CFG_TRANSPOSE, 20'd0);
    endtask

    always @(posedge i_clk) begin
        t_beat exp_b;
        if (i_rst_n && o_strobe) begin
            if (expected_beats.size() == 0) begin
                $error("unexpected result beat");
                errors++;
            end else begin
                exp_b = expected_beats.pop_front();
                if (o_out_kind !== exp_b.kind) begin
                    $error("out_kind exp %0d got %0d", exp_b.kind, o_out_kind); errors++;
                end
                if (o_out_chan !== exp_b.chan) begin
                    $error("out_chan exp %0d got %0d", exp_b.chan, o_out_chan); errors++;
                end
                if (o_out_first !== exp_b.first) begin
                    $error("out_first exp %0d got %0d", exp_b.first, o_out_first); errors++;
                end
                if (o_out_second !== exp_b.second) begin
                    $error("out_second exp %0d got %0d", exp_b.second, o_out_second);
                    errors++;
                end
                if (o_out_time !== exp_b.tstamp) begin
                    $error("out_time exp %0d got %0d", exp_b.tstamp, o_out_time); errors++;
                end
                if (o_dropped !== exp_b.dropped) begin
                    $error("dropped exp %0d got %0d", exp_b.dropped, o_dropped); errors++;
                end
                if (o_notes_full !== exp_b.full) begin
                    $error("notes_full exp %0d got %0d", exp_b.full, o_notes_full); errors++;
                end
                if (o_last_of_run !== exp_b.last) begin
                    $error("last_of_run exp %0d got %0d", exp_b.last, o_last_of_run);
                    errors++;
                end
            end
        end
    end

    initial begin
        #8_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        chan_keep = -5'sd1;
        semitones = 8'sd0;
        grid_on   = 1'b0;
        grid_unit = 20'd1;
        held_cnt  = 0;
        for (int i = 0; i < 128; i++) vel_map[i] = (i == 0) ? 7'd1 : 7'(i);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (80) @(posedge i_clk);
        test_directed_basics();
        test_filter_and_transpose();
        test_quantize();
        test_full_table();
        test_random(20, 0);
        test_random_settings();
        test_random(40, 81);
        if (expected_beats.size() != 0) begin
            $error("expected beats left over: %0d", expected_beats.size());
            errors++;
        end
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

### filelist.f
+incdir+src
src/met_pkg.sv
src/met_cell.sv
src/met_chain.sv
src/met_qdiv.sv
src/midi_event_transform_note_tracker_top.sv
src/met_checker.sv
test/tb_midi_event_transform_note_tracker_top.sv
